/* sv/gpr_pkg.sv */
// ----------------------------------------------------------------------------
// gpr_pkg
// Shared types and codes for the GPIO port register block.
// ----------------------------------------------------------------------------
package gpr_pkg;

    localparam int GRP_W = 3;  // enough for up to eight ports

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_PIN   = 2'd2;

    localparam logic [1:0] KIND_PIN = 2'd0;
    localparam logic [1:0] KIND_DIR = 2'd1;
    localparam logic [1:0] KIND_OUT = 2'd2;

    localparam logic PIN_DIR_IN  = 1'b0;
    localparam logic PIN_DIR_OUT = 1'b1;

    // decoded request, one flag at most is set
    typedef struct packed {
        logic             hit;
        logic             is_read;
        logic             is_bad_wr;
        logic             is_dir_wr;
        logic             is_out_wr;
        logic             is_pin_evt;
        logic [1:0]       kind;
        logic [GRP_W-1:0] grp;
        logic [7:0]       narrow;
        logic [7:0]       pin_bit;
    } op_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       bad_write;
        logic [1:0] port_group;
        logic [7:0] drive_mask;
        logic [7:0] drive_bits;
        logic [7:0] pullup_mask;
        logic [7:0] pullup_bits;
        logic [7:0] mode_change_mask;
        logic [7:0] mode_bits;
    } result_t;

endpackage

/* sv/gpio_port_register_model.sv */
// ----------------------------------------------------------------------------
// gpio_port_register_model
// PORT_COUNT 8-bit GPIO ports, each with pin-input, direction and output
// registers. Every request (register read, register write or external pin
// change) yields exactly one result. The block takes one request per cycle
// while the result side does not stall; a request is held in the input
// register and its result is then captured in the result register. The
// register state is read and updated by one pass of byte-wide masking logic
// between those two registers, which lets back-to-back requests see each
// other's updates without stalls. Stall on the result side holds both stages.
// ----------------------------------------------------------------------------
module gpio_port_register_model
    import gpr_pkg::*;
#(
    parameter int PORT_COUNT = 4
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] req_type,
    input  logic [3:0] reg_offset,
    input  logic [3:0] bit_select,
    input  logic [7:0] write_byte,
    input  logic [4:0] pin_number,
    input  logic       pin_level,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_byte,
    output logic       bad_write,
    output logic [1:0] port_group,
    output logic [7:0] drive_mask,
    output logic [7:0] drive_bits,
    output logic [7:0] pullup_mask,
    output logic [7:0] pullup_bits,
    output logic [7:0] mode_change_mask,
    output logic [7:0] mode_bits
);

    logic       in_valid_reg;
    logic [1:0] req_type_reg;
    logic [3:0] reg_offset_reg;
    logic [3:0] bit_select_reg;
    logic [7:0] write_byte_reg;
    logic [4:0] pin_number_reg;
    logic       pin_level_reg;

    logic       res_valid_reg;
    result_t    res_reg;
    result_t    res_next;
    op_t        op;

    logic       advance;
    logic       load;
    logic       fire;

    assign advance  = !res_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign load     = in_valid && !in_stall;
    assign fire     = in_valid_reg && advance;

    gpr_decode #(
        .PORT_COUNT (PORT_COUNT)
    ) u_decode (
        .req_type   (req_type_reg),
        .reg_offset (reg_offset_reg),
        .bit_select (bit_select_reg),
        .pin_number (pin_number_reg),
        .op         (op)
    );

    gpr_port_regs #(
        .PORT_COUNT (PORT_COUNT)
    ) u_port_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .op         (op),
        .write_byte (write_byte_reg),
        .pin_level  (pin_level_reg),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                res_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_type_reg   <= req_type;
            reg_offset_reg <= reg_offset;
            bit_select_reg <= bit_select;
            write_byte_reg <= write_byte;
            pin_number_reg <= pin_number;
            pin_level_reg  <= pin_level;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid        = res_valid_reg;
    assign read_byte        = res_reg.read_byte;
    assign bad_write        = res_reg.bad_write;
    assign port_group       = res_reg.port_group;
    assign drive_mask       = res_reg.drive_mask;
    assign drive_bits       = res_reg.drive_bits;
    assign pullup_mask      = res_reg.pullup_mask;
    assign pullup_bits      = res_reg.pullup_bits;
    assign mode_change_mask = res_reg.mode_change_mask;
    assign mode_bits        = res_reg.mode_bits;

`ifndef SYNTHESIS
    // a held request stays in the input register until the result side moves
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input register dropped a held request");

    // an output write splits every pin between driven and pull-up
    a_drive_split: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (drive_mask != 8'd0 || pullup_mask != 8'd0))
        |-> ((drive_mask ^ pullup_mask) == 8'hFF))
        else $error("drive and pull-up masks overlap or leave a gap");

    // driven levels only on driven pins
    a_drive_bits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((drive_bits & ~drive_mask) == 8'd0
                       && (pullup_bits & ~pullup_mask) == 8'd0))
        else $error("level reported outside its mask");

    // a rejected pin-input write reports nothing else
    a_bad_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_write) |-> (drive_mask == 8'd0 && pullup_mask == 8'd0
                                      && mode_bits == 8'd0 && read_byte == 8'd0))
        else $error("bad write carried other result fields");
`endif

endmodule

/* sv/gpr_decode.sv */
// ----------------------------------------------------------------------------
// gpr_decode
// Turns a registered request into port index, register kind and masks.
// ----------------------------------------------------------------------------
module gpr_decode
    import gpr_pkg::*;
#(
    parameter int PORT_COUNT = 4
)
(
    input  logic [1:0] req_type,
    input  logic [3:0] reg_offset,
    input  logic [3:0] bit_select,
    input  logic [4:0] pin_number,
    output op_t        op
);

    localparam logic [4:0] REG_COUNT = 5'(3 * PORT_COUNT);
    localparam logic [3:0] TOP_GRP   = 4'(PORT_COUNT - 1);
    localparam logic [3:0] PORT_LIM  = 4'(PORT_COUNT);

    logic [7:0] prod;
    logic [2:0] quot;
    logic [3:0] rem;
    logic [3:0] grp_w;
    logic       reg_hit;
    logic       pin_hit;

    always_comb
    begin
        // offset / 3 as multiply by 11 and shift, exact for 4-bit offsets
        prod    = {4'd0, reg_offset} * 8'd11;
        quot    = prod[7:5];
        rem     = reg_offset - 4'({1'b0, quot} * 4'd3);
        grp_w   = TOP_GRP - {1'b0, quot};
        reg_hit = ({1'b0, reg_offset} < REG_COUNT)
                  && (req_type == REQ_WRITE || req_type == REQ_READ);
        pin_hit = ({2'd0, pin_number[4:3]} < PORT_LIM) && (req_type == REQ_PIN);

        op            = '0;
        op.kind       = rem[1:0];
        op.narrow     = bit_select[3] ? 8'hFF : (8'd1 << bit_select[2:0]);
        op.pin_bit    = 8'd1 << pin_number[2:0];
        op.hit        = reg_hit || pin_hit;
        op.is_read    = reg_hit && (req_type == REQ_READ);
        op.is_bad_wr  = reg_hit && (req_type == REQ_WRITE) && (rem[1:0] == KIND_PIN);
        op.is_dir_wr  = reg_hit && (req_type == REQ_WRITE) && (rem[1:0] == KIND_DIR);
        op.is_out_wr  = reg_hit && (req_type == REQ_WRITE) && (rem[1:0] == KIND_OUT);
        op.is_pin_evt = pin_hit;
        if (reg_hit)
        begin
            op.grp = grp_w[GRP_W-1:0];
        end
        else if (pin_hit)
        begin
            op.grp = GRP_W'(pin_number[4:3]);
        end
    end

endmodule

/* sv/gpr_port_regs.sv */
// ----------------------------------------------------------------------------
// gpr_port_regs
// Pin-input, direction and output registers of every port, with the
// masking logic that forms one result and the update for one request.
// ----------------------------------------------------------------------------
module gpr_port_regs
    import gpr_pkg::*;
#(
    parameter int PORT_COUNT = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  op_t        op,
    input  logic [7:0] write_byte,
    input  logic       pin_level,
    output result_t    res
);

    localparam int IDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

    logic [7:0] pin_reg [PORT_COUNT];
    logic [7:0] dir_reg [PORT_COUNT];
    logic [7:0] out_reg [PORT_COUNT];

    logic [IDX_W-1:0] idx;
    logic [7:0]       cur_pin;
    logic [7:0]       cur_dir;
    logic [7:0]       cur_out;
    logic [7:0]       out_pins;
    logic [7:0]       drive;

    always_comb
    begin
        idx     = op.grp[IDX_W-1:0];
        cur_pin = pin_reg[idx];
        cur_dir = dir_reg[idx];
        cur_out = out_reg[idx];
        for (int i = 0; i < 8; i++)
        begin
            out_pins[i] = (cur_dir[i] == PIN_DIR_OUT);
        end
        drive = out_pins & op.narrow;

        res            = '0;
        res.port_group = op.grp[1:0];
        res.bad_write  = op.is_bad_wr;
        if (op.is_read)
        begin
            case (op.kind)
                KIND_PIN: res.read_byte = cur_pin;
                KIND_DIR: res.read_byte = cur_dir;
                default:  res.read_byte = cur_out;
            endcase
        end
        if (op.is_dir_wr)
        begin
            res.mode_change_mask = write_byte ^ cur_dir;
            res.mode_bits        = write_byte;
        end
        if (op.is_out_wr)
        begin
            res.drive_mask  = drive;
            res.drive_bits  = write_byte & drive;
            res.pullup_mask = ~drive;
            res.pullup_bits = write_byte & ~drive;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PORT_COUNT; p++)
            begin
                pin_reg[p] <= '0;
                dir_reg[p] <= {8{PIN_DIR_IN}};
                out_reg[p] <= '0;
            end
        end
        else if (fire)
        begin
            if (op.is_dir_wr)
            begin
                dir_reg[idx] <= write_byte;
            end
            if (op.is_out_wr)
            begin
                out_reg[idx] <= write_byte;
                pin_reg[idx] <= (cur_pin & ~drive) | (write_byte & drive);
            end
            if (op.is_pin_evt)
            begin
                pin_reg[idx] <= pin_level ? (cur_pin | op.pin_bit)
                                          : (cur_pin & ~op.pin_bit);
            end
        end
    end

endmodule
